/* design/dths_pkg.sv */
// shared types, constants and microcode program of the heun step core
`default_nettype none
package dths_pkg;

	localparam int CFG_W     = 31;
	localparam int CFG_IDX_W = 4;
	localparam int STEP_W    = 16;
	localparam int OUT_W     = 31;
	localparam int PC_W      = 6;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_STALL_ACCEL    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_SLOPE    = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLIP_ACCEL     = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GRIP_ACCEL     = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ROLLING_ACCEL  = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ROLLING_SLOPE  = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP      = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_AMPS_PER_ACCEL = 4'd7;

	localparam logic [CFG_W-1:0] RST_STALL_ACCEL    = 31'd931400;
	localparam logic [CFG_W-1:0] RST_ACCEL_SLOPE    = 31'd264840;
	localparam logic [CFG_W-1:0] RST_SLIP_ACCEL     = 31'd642689;
	localparam logic [CFG_W-1:0] RST_GRIP_ACCEL     = 31'd449882;
	localparam logic [CFG_W-1:0] RST_ROLLING_ACCEL  = 31'd42847;
	localparam logic [CFG_W-1:0] RST_ROLLING_SLOPE  = 31'd0;
	localparam logic [CFG_W-1:0] RST_TIME_STEP      = 31'd6554;
	localparam logic [CFG_W-1:0] RST_AMPS_PER_ACCEL = 31'd405995;

	typedef struct packed {
		logic [CFG_W-1:0] stall_accel;
		logic [CFG_W-1:0] accel_slope;
		logic [CFG_W-1:0] slip_accel;
		logic [CFG_W-1:0] grip_accel;
		logic [CFG_W-1:0] rolling_accel;
		logic [CFG_W-1:0] rolling_slope;
		logic [CFG_W-1:0] time_step;
		logic [CFG_W-1:0] amps_per_accel;
	} cfg_t;

	typedef struct packed {
		logic [STEP_W-1:0] step_count;
		logic [OUT_W-1:0]  position;
		logic [OUT_W-1:0]  speed;
		logic              slipping;
		logic [OUT_W-1:0]  acceleration;
		logic [OUT_W-1:0]  motor_current;
	} res_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_MLO,
		OP_MHI,
		OP_MSAT,
		OP_ADD,
		OP_ADDS,
		OP_ADDH,
		OP_SUB,
		OP_SUBS,
		OP_SLIP,
		OP_CLR
	} op_t;

	typedef enum logic [3:0] {
		A_SPD,
		A_POS,
		A_ACC,
		A_TV,
		A_TAV,
		A_TDR,
		A_TNET,
		A_STALL,
		A_RACC
	} asel_t;

	typedef enum logic [2:0] {
		B_ZERO,
		B_TV,
		B_TAV,
		B_TL,
		B_TNET
	} bsel_t;

	typedef enum logic [1:0] {
		M_SLOPE,
		M_AMPS,
		M_RSLOPE,
		M_DT
	} msel_t;

	typedef enum logic [3:0] {
		D_NONE,
		D_SPD,
		D_POS,
		D_ACC,
		D_CUR,
		D_TV,
		D_TAV,
		D_TDR,
		D_TL,
		D_TNET
	} dst_t;

	typedef enum logic [2:0] {
		J_NEXT,
		J_BRST,
		J_CALL,
		J_RET,
		J_GOTO,
		J_END
	} jmp_t;

	typedef struct packed {
		op_t             op;
		asel_t           asel;
		bsel_t           bsel;
		msel_t           msel;
		dst_t            dst;
		jmp_t            jmp;
		logic [PC_W-1:0] target;
		logic            step_inc;
	} ctl_t;

	// program entry points
	localparam logic [PC_W-1:0] PC_ENTRY   = 6'd0;
	localparam logic [PC_W-1:0] PC_RESTART = 6'd17;
	localparam logic [PC_W-1:0] PC_OUT     = 6'd19;
	localparam logic [PC_W-1:0] PC_ACCEL   = 6'd20;

	localparam ctl_t CW_IDLE = '{op: OP_NOP, asel: A_SPD, bsel: B_ZERO, msel: M_DT,
		dst: D_NONE, jmp: J_NEXT, target: PC_ENTRY, step_inc: 1'b0};

	// width of the multiplier's data operand
	function automatic int calc_aw(input int word_bits);
		return (word_bits - 1 > CFG_W) ? word_bits - 1 : CFG_W;
	endfunction

	// width of the signed datapath words
	function automatic int calc_sw(input int word_bits);
		return ((word_bits > CFG_W + 1) ? word_bits : CFG_W + 1) + 2;
	endfunction

	function automatic ctl_t cw(input op_t op, input asel_t a, input bsel_t b,
			input msel_t m, input dst_t d, input jmp_t j, input logic [PC_W-1:0] t,
			input logic si);
		ctl_t c;
		c.op       = op;
		c.asel     = a;
		c.bsel     = b;
		c.msel     = m;
		c.dst      = d;
		c.jmp      = j;
		c.target   = t;
		c.step_inc = si;
		return c;
	endfunction

	// control store: step body, restart body, result hand-off, accel subroutine
	function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
		ctl_t c;
		c = CW_IDLE;
		unique case (pc)
			6'd0:  c = cw(OP_NOP,  A_SPD,   B_ZERO, M_DT,     D_NONE, J_BRST, PC_RESTART, 1'b0);
			// predictor: vp = v + a*dt
			6'd1:  c = cw(OP_MLO,  A_ACC,   B_ZERO, M_DT,     D_NONE, J_NEXT, PC_ENTRY,   1'b0);
			6'd2:  c = cw(OP_MHI,  A_ACC,   B_ZERO, M_DT,     D_NONE, J_NEXT, PC_ENTRY,   1'b0);
			6'd3:  c = cw(OP_MSAT, A_ACC,   B_ZERO, M_DT,     D_TV,   J_NEXT, PC_ENTRY,   1'b0);
			6'd4:  c = cw(OP_ADDS, A_SPD,   B_TV,   M_DT,     D_TV,   J_CALL, PC_ACCEL,   1'b0);
			// corrector: vn = v + ((a+ap)>>1)*dt
			6'd5:  c = cw(OP_ADDH, A_ACC,   B_TNET, M_DT,     D_TV,   J_NEXT, PC_ENTRY,   1'b0);
			6'd6:  c = cw(OP_MLO,  A_TV,    B_ZERO, M_DT,     D_NONE, J_NEXT, PC_ENTRY,   1'b0);
			6'd7:  c = cw(OP_MHI,  A_TV,    B_ZERO, M_DT,     D_NONE, J_NEXT, PC_ENTRY,   1'b0);
			6'd8:  c = cw(OP_MSAT, A_TV,    B_ZERO, M_DT,     D_TV,   J_NEXT, PC_ENTRY,   1'b0);
			6'd9:  c = cw(OP_ADDS, A_SPD,   B_TV,   M_DT,     D_TV,   J_CALL, PC_ACCEL,   1'b0);
			6'd10: c = cw(OP_ADD,  A_TNET,  B_ZERO, M_DT,     D_ACC,  J_NEXT, PC_ENTRY,   1'b0);
			// position: x + ((v+vn)>>1)*dt
			6'd11: c = cw(OP_ADDH, A_SPD,   B_TV,   M_DT,     D_TAV,  J_NEXT, PC_ENTRY,   1'b0);
			6'd12: c = cw(OP_MLO,  A_TAV,   B_ZERO, M_DT,     D_NONE, J_NEXT, PC_ENTRY,   1'b0);
			6'd13: c = cw(OP_MHI,  A_TAV,   B_ZERO, M_DT,     D_NONE, J_NEXT, PC_ENTRY,   1'b0);
			6'd14: c = cw(OP_MSAT, A_TAV,   B_ZERO, M_DT,     D_TAV,  J_NEXT, PC_ENTRY,   1'b0);
			6'd15: c = cw(OP_ADDS, A_POS,   B_TAV,  M_DT,     D_POS,  J_NEXT, PC_ENTRY,   1'b0);
			6'd16: c = cw(OP_ADD,  A_TV,    B_ZERO, M_DT,     D_SPD,  J_GOTO, PC_OUT,     1'b1);
			// restart
			6'd17: c = cw(OP_CLR,  A_SPD,   B_ZERO, M_DT,     D_NONE, J_CALL, PC_ACCEL,   1'b0);
			6'd18: c = cw(OP_ADD,  A_TNET,  B_ZERO, M_DT,     D_ACC,  J_NEXT, PC_ENTRY,   1'b0);
			6'd19: c = cw(OP_NOP,  A_SPD,   B_ZERO, M_DT,     D_NONE, J_END,  PC_ENTRY,   1'b0);
			// accel subroutine on tv, net result in tnet
			6'd20: c = cw(OP_MLO,  A_TV,    B_ZERO, M_SLOPE,  D_NONE, J_NEXT, PC_ENTRY,   1'b0);
			6'd21: c = cw(OP_MHI,  A_TV,    B_ZERO, M_SLOPE,  D_NONE, J_NEXT, PC_ENTRY,   1'b0);
			6'd22: c = cw(OP_MSAT, A_TV,    B_ZERO, M_SLOPE,  D_TAV,  J_NEXT, PC_ENTRY,   1'b0);
			6'd23: c = cw(OP_SUB,  A_STALL, B_TAV,  M_SLOPE,  D_TAV,  J_NEXT, PC_ENTRY,   1'b0);
			6'd24: c = cw(OP_SLIP, A_TAV,   B_ZERO, M_SLOPE,  D_TDR,  J_NEXT, PC_ENTRY,   1'b0);
			6'd25: c = cw(OP_MLO,  A_TDR,   B_ZERO, M_AMPS,   D_NONE, J_NEXT, PC_ENTRY,   1'b0);
			6'd26: c = cw(OP_MHI,  A_TDR,   B_ZERO, M_AMPS,   D_NONE, J_NEXT, PC_ENTRY,   1'b0);
			6'd27: c = cw(OP_MSAT, A_TDR,   B_ZERO, M_AMPS,   D_CUR,  J_NEXT, PC_ENTRY,   1'b0);
			6'd28: c = cw(OP_MLO,  A_TV,    B_ZERO, M_RSLOPE, D_NONE, J_NEXT, PC_ENTRY,   1'b0);
			6'd29: c = cw(OP_MHI,  A_TV,    B_ZERO, M_RSLOPE, D_NONE, J_NEXT, PC_ENTRY,   1'b0);
			6'd30: c = cw(OP_MSAT, A_TV,    B_ZERO, M_RSLOPE, D_TL,   J_NEXT, PC_ENTRY,   1'b0);
			6'd31: c = cw(OP_ADDS, A_RACC,  B_TL,   M_RSLOPE, D_TL,   J_NEXT, PC_ENTRY,   1'b0);
			6'd32: c = cw(OP_SUBS, A_TDR,   B_TL,   M_RSLOPE, D_TNET, J_RET,  PC_ENTRY,   1'b0);
			default: c = cw(OP_NOP, A_SPD,  B_ZERO, M_DT,     D_NONE, J_END,  PC_ENTRY,   1'b0);
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

/* design/drivetrain_heun_step_core.sv */
// top level: one heun step of a motor-driven vehicle with wheel slip per input transaction,
// or a restart when restart is set. one control word issues per cycle, the end word
// holding until the result register is free; the result is valid the cycle after the end
// word is taken. the shared two-pass multiplier (low half, high half, saturate) forms 9
// products per step; a new transaction is accepted only while idle (in_stall low).
// arst_n clears the state, the sequencer and out_valid and loads the register defaults.
`default_nettype none
module drivetrain_heun_step_core #(
	parameter int FRAC_BITS = 16,
	parameter int WORD_BITS = 32
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  wire                                 restart,
	output logic                                out_valid,
	input  wire                                 out_stall,
	output logic [dths_pkg::STEP_W-1:0]         step_count,
	output logic [dths_pkg::OUT_W-1:0]          position,
	output logic [dths_pkg::OUT_W-1:0]          speed,
	output logic                                slipping,
	output logic [dths_pkg::OUT_W-1:0]          acceleration,
	output logic [dths_pkg::OUT_W-1:0]          motor_current,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire [dths_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [dths_pkg::CFG_W-1:0]           cfg_data
);

	dths_pkg::cfg_t cfg;
	dths_pkg::ctl_t ctl;
	dths_pkg::res_t res;
	dths_pkg::res_t res_q;
	logic           out_valid_q;
	logic           out_load;
	logic           slot_free;

	assign cfg_ready = 1'b1;
	assign slot_free = !out_valid_q || !out_stall;

	dths_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_valid && cfg_ready),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	dths_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.restart   (restart),
		.slot_free (slot_free),
		.in_stall  (in_stall),
		.ctl       (ctl),
		.out_load  (out_load)
	);

	dths_dp #(
		.FRAC_BITS (FRAC_BITS),
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) res_q <= res;
	end

	assign out_valid     = out_valid_q;
	assign step_count    = res_q.step_count;
	assign position      = res_q.position;
	assign speed         = res_q.speed;
	assign slipping      = res_q.slipping;
	assign acceleration  = res_q.acceleration;
	assign motor_current = res_q.motor_current;

endmodule
`default_nettype wire

/* design/dths_cfg.sv */
// configuration register file
`default_nettype none
module dths_cfg (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               we,
	input  wire [dths_pkg::CFG_IDX_W-1:0]     index,
	input  wire [dths_pkg::CFG_W-1:0]         data,
	output dths_pkg::cfg_t                    cfg
);

	dths_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stall_accel    <= dths_pkg::RST_STALL_ACCEL;
			cfg_q.accel_slope    <= dths_pkg::RST_ACCEL_SLOPE;
			cfg_q.slip_accel     <= dths_pkg::RST_SLIP_ACCEL;
			cfg_q.grip_accel     <= dths_pkg::RST_GRIP_ACCEL;
			cfg_q.rolling_accel  <= dths_pkg::RST_ROLLING_ACCEL;
			cfg_q.rolling_slope  <= dths_pkg::RST_ROLLING_SLOPE;
			cfg_q.time_step      <= dths_pkg::RST_TIME_STEP;
			cfg_q.amps_per_accel <= dths_pkg::RST_AMPS_PER_ACCEL;
		end else if (we) begin
			unique case (index)
				dths_pkg::CFG_STALL_ACCEL:    cfg_q.stall_accel    <= data;
				dths_pkg::CFG_ACCEL_SLOPE:    cfg_q.accel_slope    <= data;
				dths_pkg::CFG_SLIP_ACCEL:     cfg_q.slip_accel     <= data;
				dths_pkg::CFG_GRIP_ACCEL:     cfg_q.grip_accel     <= data;
				dths_pkg::CFG_ROLLING_ACCEL:  cfg_q.rolling_accel  <= data;
				dths_pkg::CFG_ROLLING_SLOPE:  cfg_q.rolling_slope  <= data;
				dths_pkg::CFG_TIME_STEP:      cfg_q.time_step      <= data;
				dths_pkg::CFG_AMPS_PER_ACCEL: cfg_q.amps_per_accel <= data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

/* design/dths_mul.sv */
// two-pass fixed-point multiplier with truncation and saturation
`default_nettype none
module dths_mul #(
	parameter int FRAC_BITS = 16,
	parameter int WORD_BITS = 32
) (
	input  wire                                              clk,
	input  wire                                              lo_en,
	input  wire                                              hi_en,
	input  wire [dths_pkg::calc_aw(WORD_BITS)-1:0]           a,
	input  wire [dths_pkg::CFG_W-1:0]                        b,
	output logic signed [dths_pkg::calc_sw(WORD_BITS)-1:0]   prod
);

	localparam int AW    = dths_pkg::calc_aw(WORD_BITS);
	localparam int SW    = dths_pkg::calc_sw(WORD_BITS);
	localparam int BW    = dths_pkg::CFG_W;
	localparam int HW    = (AW + 1) / 2;
	localparam int UW    = AW - HW;
	localparam int LO_PW = HW + BW;
	localparam int HI_PW = UW + BW;
	localparam int FW    = AW + BW + 1;
	localparam logic [FW-1:0] VMAX_F = {{(FW-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};

	logic [LO_PW-1:0] pp_lo_q;
	logic [HI_PW-1:0] pp_hi_q;
	logic [FW-1:0]    full;
	logic [FW-1:0]    shifted;

	// low half first, high half on the next control step
	always_ff @(posedge clk) begin
		if (lo_en) begin
			pp_lo_q <= LO_PW'(a[HW-1:0]) * LO_PW'(b);
		end
		if (hi_en) begin
			pp_hi_q <= HI_PW'(a[AW-1:HW]) * HI_PW'(b);
		end
	end

	always_comb begin
		full    = (FW'(pp_hi_q) << HW) + FW'(pp_lo_q);
		shifted = full >> FRAC_BITS;
		if (shifted > VMAX_F) begin
			prod = $signed(VMAX_F[SW-1:0]);
		end else begin
			prod = $signed(shifted[SW-1:0]);
		end
	end

endmodule
`default_nettype wire

/* design/dths_dp.sv */
// datapath: state and scratch registers, alu, slip logic, shared multiplier
`default_nettype none
module dths_dp #(
	parameter int FRAC_BITS = 16,
	parameter int WORD_BITS = 32
) (
	input  wire             clk,
	input  wire             arst_n,
	input  dths_pkg::ctl_t  ctl,
	input  dths_pkg::cfg_t  cfg,
	output dths_pkg::res_t  res
);

	localparam int AW    = dths_pkg::calc_aw(WORD_BITS);
	localparam int SW    = dths_pkg::calc_sw(WORD_BITS);
	localparam int CW    = dths_pkg::CFG_W;
	localparam int OW    = dths_pkg::OUT_W;
	localparam int STW   = dths_pkg::STEP_W;
	localparam logic signed [SW-1:0] VMAX    = {{(SW-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
	localparam logic signed [SW-1:0] OUT_LIM = {{(SW-OW){1'b0}}, {OW{1'b1}}};

	function automatic logic signed [SW-1:0] ext(input logic [CW-1:0] v);
		return $signed({{(SW-CW){1'b0}}, v});
	endfunction

	function automatic logic signed [SW-1:0] sat_v(input logic signed [SW-1:0] x);
		logic signed [SW-1:0] r;
		if (x > VMAX) begin
			r = VMAX;
		end else if (x < $signed({SW{1'b0}})) begin
			r = '0;
		end else begin
			r = x;
		end
		return r;
	endfunction

	function automatic logic [OW-1:0] clip(input logic signed [SW-1:0] x);
		logic [OW-1:0] r;
		if (x > OUT_LIM) begin
			r = '1;
		end else begin
			r = x[OW-1:0];
		end
		return r;
	endfunction

	logic signed [SW-1:0] spd_q, pos_q, acc_q, cur_q;
	logic                 slip_q;
	logic [STW-1:0]       step_q;
	logic signed [SW-1:0] tv_q, tav_q, tdr_q, tl_q, tnet_q;

	logic signed [SW-1:0] a_bus, b_bus, sum, diff, prod, wb, drive;
	logic [AW-1:0]        mul_a;
	logic [CW-1:0]        mul_b;
	logic                 wr_en, slip_n;

	always_comb begin
		unique case (ctl.asel)
			dths_pkg::A_SPD:   a_bus = spd_q;
			dths_pkg::A_POS:   a_bus = pos_q;
			dths_pkg::A_ACC:   a_bus = acc_q;
			dths_pkg::A_TV:    a_bus = tv_q;
			dths_pkg::A_TAV:   a_bus = tav_q;
			dths_pkg::A_TDR:   a_bus = tdr_q;
			dths_pkg::A_TNET:  a_bus = tnet_q;
			dths_pkg::A_STALL: a_bus = ext(cfg.stall_accel);
			dths_pkg::A_RACC:  a_bus = ext(cfg.rolling_accel);
			default:           a_bus = '0;
		endcase
	end

	always_comb begin
		unique case (ctl.bsel)
			dths_pkg::B_ZERO: b_bus = '0;
			dths_pkg::B_TV:   b_bus = tv_q;
			dths_pkg::B_TAV:  b_bus = tav_q;
			dths_pkg::B_TL:   b_bus = tl_q;
			dths_pkg::B_TNET: b_bus = tnet_q;
			default:          b_bus = '0;
		endcase
	end

	always_comb begin
		unique case (ctl.msel)
			dths_pkg::M_SLOPE:  mul_b = cfg.accel_slope;
			dths_pkg::M_AMPS:   mul_b = cfg.amps_per_accel;
			dths_pkg::M_RSLOPE: mul_b = cfg.rolling_slope;
			dths_pkg::M_DT:     mul_b = cfg.time_step;
			default:            mul_b = '0;
		endcase
	end

	// a negative operand multiplies as zero, so a negative drive yields zero current
	assign mul_a = a_bus[SW-1] ? '0 : a_bus[AW-1:0];

	dths_mul #(
		.FRAC_BITS (FRAC_BITS),
		.WORD_BITS (WORD_BITS)
	) u_mul (
		.clk   (clk),
		.lo_en (ctl.op == dths_pkg::OP_MLO),
		.hi_en (ctl.op == dths_pkg::OP_MHI),
		.a     (mul_a),
		.b     (mul_b),
		.prod  (prod)
	);

	assign sum  = a_bus + b_bus;
	assign diff = a_bus - b_bus;

	// slip hysteresis on the available force held in tav
	always_comb begin
		priority if (tav_q > ext(cfg.slip_accel)) begin
			slip_n = 1'b1;
		end else if (tav_q < ext(cfg.grip_accel)) begin
			slip_n = 1'b0;
		end else begin
			slip_n = slip_q;
		end
		drive = slip_n ? ext(cfg.grip_accel) : tav_q;
	end

	always_comb begin
		wr_en = 1'b1;
		unique case (ctl.op)
			dths_pkg::OP_MSAT: wb = prod;
			dths_pkg::OP_ADD:  wb = sum;
			dths_pkg::OP_ADDS: wb = sat_v(sum);
			dths_pkg::OP_ADDH: wb = sum >>> 1;
			dths_pkg::OP_SUB:  wb = diff;
			dths_pkg::OP_SUBS: wb = sat_v(diff);
			dths_pkg::OP_SLIP: wb = drive;
			default: begin
				wb    = '0;
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spd_q  <= '0;
			pos_q  <= '0;
			acc_q  <= '0;
			cur_q  <= '0;
			slip_q <= 1'b0;
			step_q <= '0;
		end else if (ctl.op == dths_pkg::OP_CLR) begin
			spd_q  <= '0;
			pos_q  <= '0;
			slip_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (wr_en && ctl.dst == dths_pkg::D_SPD) spd_q <= wb;
			if (wr_en && ctl.dst == dths_pkg::D_POS) pos_q <= wb;
			if (wr_en && ctl.dst == dths_pkg::D_ACC) acc_q <= wb;
			if (wr_en && ctl.dst == dths_pkg::D_CUR) cur_q <= wb;
			if (ctl.op == dths_pkg::OP_SLIP) slip_q <= slip_n;
			if (ctl.step_inc && step_q != '1) step_q <= step_q + STW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.op == dths_pkg::OP_CLR) begin
			tv_q <= '0;
		end else if (wr_en && ctl.dst == dths_pkg::D_TV) begin
			tv_q <= wb;
		end
		if (wr_en && ctl.dst == dths_pkg::D_TAV)  tav_q  <= wb;
		if (wr_en && ctl.dst == dths_pkg::D_TDR)  tdr_q  <= wb;
		if (wr_en && ctl.dst == dths_pkg::D_TL)   tl_q   <= wb;
		if (wr_en && ctl.dst == dths_pkg::D_TNET) tnet_q <= wb;
	end

	always_comb begin
		res.step_count    = step_q;
		res.position      = clip(pos_q);
		res.speed         = clip(spd_q);
		res.slipping      = slip_q;
		res.acceleration  = clip(acc_q);
		res.motor_current = clip(cur_q);
	end

endmodule
`default_nettype wire

/* design/dths_seq.sv */
// microcode sequencer: program counter, return register, entry dispatch
`default_nettype none
module dths_seq (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	input  wire             restart,
	input  wire             slot_free,
	output logic            in_stall,
	output dths_pkg::ctl_t  ctl,
	output logic            out_load
);

	localparam int PW = dths_pkg::PC_W;

	logic          busy_q;
	logic          restart_q;
	logic [PW-1:0] pc_q;
	logic [PW-1:0] ret_q;
	dths_pkg::ctl_t cw;

	assign cw       = dths_pkg::ucode(pc_q);
	assign in_stall = busy_q;
	assign ctl      = busy_q ? cw : dths_pkg::CW_IDLE;
	assign out_load = busy_q && (cw.jmp == dths_pkg::J_END) && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			restart_q <= 1'b0;
			pc_q      <= dths_pkg::PC_ENTRY;
			ret_q     <= dths_pkg::PC_ENTRY;
		end else if (!busy_q) begin
			if (in_valid) begin
				busy_q    <= 1'b1;
				restart_q <= restart;
				pc_q      <= dths_pkg::PC_ENTRY;
			end
		end else begin
			unique case (cw.jmp)
				dths_pkg::J_NEXT: pc_q <= pc_q + PW'(1);
				dths_pkg::J_BRST: pc_q <= restart_q ? cw.target : pc_q + PW'(1);
				dths_pkg::J_CALL: begin
					ret_q <= pc_q + PW'(1);
					pc_q  <= cw.target;
				end
				dths_pkg::J_RET:  pc_q <= ret_q;
				dths_pkg::J_GOTO: pc_q <= cw.target;
				dths_pkg::J_END: begin
					// hold here until the result register can take the transaction
					if (slot_free) busy_q <= 1'b0;
				end
				default: busy_q <= 1'b0;
			endcase
		end
	end

endmodule
`default_nettype wire

/* verif/drivetrain_heun_step_core_tb.sv */
`timescale 1ns / 100ps
// self-checking bench for the heun step core: directed table, then random settings and traffic
module drivetrain_heun_step_core_tb;
	import dths_pkg::*;

	localparam int     FRAC          = 16;
	localparam int     WORD          = 32;
	localparam longint WMAX          = (64'sd1 <<< (WORD - 1)) - 1;
	localparam longint ONE           = 64'sd1 <<< FRAC;
	localparam int     HALF_PERIOD   = 10;
	localparam int     SETTLE_CYCLES = 50;
	localparam int     HOLD_AT       = 60;
	localparam int     HOLD_CYCLES   = 300;
	localparam int     PHASES        = 12;
	localparam int     RANDOM_ITEMS  = 1932;
	localparam int     TIMEOUT_NS    = 20_000_000;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_AMPS_PER_ACCEL + 4'd1;
	localparam logic [CFG_W-1:0]     CFG_ONE         = CFG_W'(ONE);

	localparam cfg_t BOOT_SETTINGS = '{RST_STALL_ACCEL, RST_ACCEL_SLOPE, RST_SLIP_ACCEL,
		RST_GRIP_ACCEL, RST_ROLLING_ACCEL, RST_ROLLING_SLOPE, RST_TIME_STEP,
		RST_AMPS_PER_ACCEL};

	typedef enum int {
		PRESET_BOOT,
		PRESET_TOP,
		PRESET_ZERO,
		PRESET_SLIP,
		PRESET_FALLOFF
	} preset_t;

	typedef struct {
		preset_t preset;
		bit      restart_bit;
		bit      known;
		res_t    want;
	} row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic                 restart;
	logic                 out_valid;
	logic                 out_stall;
	logic [STEP_W-1:0]    step_count;
	logic [OUT_W-1:0]     position;
	logic [OUT_W-1:0]     speed;
	logic                 slipping;
	logic [OUT_W-1:0]     acceleration;
	logic [OUT_W-1:0]     motor_current;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// vehicle model state and its copy of the registers
	cfg_t              model_cfg;
	longint            model_speed;
	longint            model_pos;
	longint            model_accel;
	longint            model_current;
	bit                model_slip;
	logic [STEP_W-1:0] model_steps;

	res_t results_due[$];
	row_t directed[$];

	int mismatches      = 0;
	int results_checked = 0;
	int items_sent      = 0;
	int restarts_sent   = 0;
	int settings_loaded = 0;
	int slip_edges      = 0;
	int top_speed_hits  = 0;
	int gap_max         = 16;
	int stall_max       = 16;

	drivetrain_heun_step_core #(
		.FRAC_BITS(FRAC),
		.WORD_BITS(WORD)
	) i_dut (.*);

	initial clk = 1'b0;
	always #(HALF_PERIOD) clk = ~clk;

	function automatic longint fx_mul(longint a, longint b);
		longint p;
		p = (a * b) >>> FRAC;
		return (p > WMAX) ? WMAX : p;
	endfunction

	function automatic longint clamp_word(longint v);
		if (v > WMAX)
			return WMAX;
		if (v < 0)
			return 0;
		return v;
	endfunction

	// net accel at speed v; moves the slip latch and the motor current
	function automatic longint wheel_accel(longint v);
		longint avail;
		longint drive;
		longint loss;
		avail = longint'(model_cfg.stall_accel) - fx_mul(longint'(model_cfg.accel_slope), v);
		if (avail > longint'(model_cfg.slip_accel))
			model_slip = 1'b1;
		else if (avail < longint'(model_cfg.grip_accel))
			model_slip = 1'b0;
		drive = model_slip ? longint'(model_cfg.grip_accel) : avail;
		model_current = (drive > 0) ? fx_mul(drive, longint'(model_cfg.amps_per_accel)) : 0;
		loss = clamp_word(longint'(model_cfg.rolling_accel)
			+ fx_mul(longint'(model_cfg.rolling_slope), v));
		return clamp_word(drive - loss);
	endfunction

	function automatic res_t result_of(longint steps, longint pos, longint spd, bit slip,
			longint acc, longint cur);
		res_t r;
		r.step_count    = STEP_W'(steps);
		r.position      = OUT_W'(pos);
		r.speed         = OUT_W'(spd);
		r.slipping      = slip;
		r.acceleration  = OUT_W'(acc);
		r.motor_current = OUT_W'(cur);
		return r;
	endfunction

	// trapezoidal predictor-corrector step, or a restart at t=0
	function automatic res_t heun_step_result(bit rst);
		longint v0;
		longint vp;
		longint ap;
		longint vn;
		longint dt;
		dt = longint'(model_cfg.time_step);
		if (rst) begin
			model_speed = 0;
			model_pos   = 0;
			model_steps = '0;
			model_slip  = 1'b0;
			model_accel = wheel_accel(0);
		end else begin
			v0 = model_speed;
			vp = clamp_word(v0 + fx_mul(model_accel, dt));
			ap = wheel_accel(vp);
			vn = clamp_word(v0 + fx_mul((model_accel + ap) >>> 1, dt));
			model_accel = wheel_accel(vn);
			model_pos   = clamp_word(model_pos + fx_mul((v0 + vn) >>> 1, dt));
			model_speed = vn;
			if (model_steps != '1)
				model_steps++;
		end
		return result_of(longint'(model_steps), model_pos, model_speed, model_slip,
			model_accel, model_current);
	endfunction

	function automatic cfg_t preset_settings(preset_t p);
		cfg_t c;
		c = BOOT_SETTINGS;
		case (p)
			PRESET_TOP: begin
				c = '0;
				c.stall_accel = '1;
				c.slip_accel  = '1;
				c.time_step   = '1;
			end
			PRESET_ZERO: c = '0;
			PRESET_SLIP: begin
				c = '0;
				c.stall_accel    = '1;
				c.grip_accel     = CFG_ONE;
				c.amps_per_accel = CFG_ONE;
			end
			// force falls off steeply with speed, so the available force goes negative
			PRESET_FALLOFF: begin
				c = '0;
				c.stall_accel    = CFG_ONE;
				c.accel_slope    = '1;
				c.slip_accel     = '1;
				c.time_step      = CFG_ONE;
				c.amps_per_accel = CFG_ONE;
			end
			default: ;
		endcase
		return c;
	endfunction

	// a register value spread around its power-up default
	function automatic logic [CFG_W-1:0] near(logic [CFG_W-1:0] base);
		return CFG_W'((longint'(base) * longint'($urandom_range(40, 100))) >> 6);
	endfunction

	function automatic logic [CFG_W-1:0] wild(int mode);
		if (mode == 1)
			return CFG_W'($urandom);
		case ($urandom_range(0, 3))
			0:       return '0;
			1:       return '1;
			2:       return CFG_W'($urandom_range(0, 1 << 20));
			default: return CFG_W'($urandom);
		endcase
	endfunction

	function automatic cfg_t draw_settings(int mode);
		cfg_t c;
		if (mode == 0) begin
			c.stall_accel    = near(RST_STALL_ACCEL);
			c.accel_slope    = near(RST_ACCEL_SLOPE);
			c.slip_accel     = near(RST_SLIP_ACCEL);
			c.grip_accel     = near(RST_GRIP_ACCEL);
			c.rolling_accel  = near(RST_ROLLING_ACCEL);
			c.rolling_slope  = CFG_W'($urandom_range(0, 20000));
			c.time_step      = CFG_W'($urandom_range(1600, 13000));
			c.amps_per_accel = near(RST_AMPS_PER_ACCEL);
		end else begin
			c = {wild(mode), wild(mode), wild(mode), wild(mode),
				wild(mode), wild(mode), wild(mode), wild(mode)};
		end
		return c;
	endfunction

	task automatic add_row(preset_t p, bit rst, bit known, res_t want);
		row_t r;
		r.preset      = p;
		r.restart_bit = rst;
		r.known       = known;
		r.want        = want;
		directed.push_back(r);
	endtask

	// leaves cfg_valid high so back-to-back writes need no second assignment
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_STALL_ACCEL:    model_cfg.stall_accel    = data;
			CFG_ACCEL_SLOPE:    model_cfg.accel_slope    = data;
			CFG_SLIP_ACCEL:     model_cfg.slip_accel     = data;
			CFG_GRIP_ACCEL:     model_cfg.grip_accel     = data;
			CFG_ROLLING_ACCEL:  model_cfg.rolling_accel  = data;
			CFG_ROLLING_SLOPE:  model_cfg.rolling_slope  = data;
			CFG_TIME_STEP:      model_cfg.time_step      = data;
			CFG_AMPS_PER_ACCEL: model_cfg.amps_per_accel = data;
			default: ;
		endcase
	endtask

	task automatic load_settings(cfg_t c);
		write_reg(CFG_STALL_ACCEL, c.stall_accel);
		write_reg(CFG_ACCEL_SLOPE, c.accel_slope);
		write_reg(CFG_SLIP_ACCEL, c.slip_accel);
		write_reg(CFG_GRIP_ACCEL, c.grip_accel);
		write_reg(CFG_ROLLING_ACCEL, c.rolling_accel);
		write_reg(CFG_ROLLING_SLOPE, c.rolling_slope);
		write_reg(CFG_TIME_STEP, c.time_step);
		write_reg(CFG_AMPS_PER_ACCEL, c.amps_per_accel);
		// last, so a write past the register file cannot hide behind a later one
		write_reg(CFG_SPARE_FIRST + CFG_IDX_W'($urandom_range(0, 7)), CFG_W'($urandom));
		cfg_valid <= 1'b0;
		settings_loaded++;
	endtask

	// called at the edge of the last input transaction; waits until the core is idle
	task automatic settle();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (results_due.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic offer(bit rst, bit known, res_t want);
		int   gap;
		res_t predicted;
		gap = $urandom_range(0, gap_max);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		restart  <= rst;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = heun_step_result(rst);
		results_due.push_back(known ? want : predicted);
		items_sent++;
		if (rst)
			restarts_sent++;
	endtask

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%s mismatch in result %0d: expected %0d, got %0d",
					name, results_checked, want, got);
		end
	endtask

	initial begin : result_sink
		int   hold_left;
		bit   prev_slip;
		res_t got;
		res_t want;
		hold_left = 0;
		prev_slip = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				got = {step_count, position, speed, slipping, acceleration, motor_current};
				if (results_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result transaction with nothing expected at %0t, step %0d",
							$realtime, got.step_count);
				end else begin
					want = results_due.pop_front();
					compare_field("step_count", 32'(want.step_count), 32'(got.step_count));
					compare_field("position", 32'(want.position), 32'(got.position));
					compare_field("speed", 32'(want.speed), 32'(got.speed));
					compare_field("slipping", 32'(want.slipping), 32'(got.slipping));
					compare_field("acceleration", 32'(want.acceleration),
						32'(got.acceleration));
					compare_field("motor_current", 32'(want.motor_current),
						32'(got.motor_current));
				end
				results_checked++;
				if (got.slipping != prev_slip)
					slip_edges++;
				prev_slip = got.slipping;
				if (got.speed == '1)
					top_speed_hits++;
				// one long hold-off lets the core back up into its input
				hold_left = (results_checked == HOLD_AT) ? HOLD_CYCLES
					: $urandom_range(0, stall_max);
			end else if (out_valid && hold_left > 0) begin
				hold_left--;
			end
			out_stall <= (hold_left > 0);
		end
	end

	initial begin : stimulus
		preset_t active_preset;
		int      per_phase;
		int      mode;
		int      restart_pct;
		bit      rst;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		restart   <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_STALL_ACCEL;
		cfg_data  <= '0;
		model_cfg     = BOOT_SETTINGS;
		model_speed   = 0;
		model_pos     = 0;
		model_accel   = 0;
		model_current = 0;
		model_slip    = 1'b0;
		model_steps   = '0;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// the first transaction steps straight out of reset, without a restart
		add_row(PRESET_BOOT, 1'b0, 1'b0, '0);
		add_row(PRESET_BOOT, 1'b1, 1'b0, '0);
		repeat (3)
			add_row(PRESET_BOOT, 1'b0, 1'b0, '0);
		add_row(PRESET_TOP, 1'b1, 1'b1, result_of(0, 0, 0, 1'b0, WMAX, 0));
		add_row(PRESET_TOP, 1'b0, 1'b1, result_of(1, WMAX, WMAX, 1'b0, WMAX, 0));
		add_row(PRESET_TOP, 1'b0, 1'b1, result_of(2, WMAX, WMAX, 1'b0, WMAX, 0));
		// zero time step: speed and position stay put
		add_row(PRESET_ZERO, 1'b1, 1'b1, result_of(0, 0, 0, 1'b0, 0, 0));
		add_row(PRESET_ZERO, 1'b0, 1'b1, result_of(1, 0, 0, 1'b0, 0, 0));
		add_row(PRESET_SLIP, 1'b1, 1'b1, result_of(0, 0, 0, 1'b1, ONE, ONE));
		add_row(PRESET_SLIP, 1'b0, 1'b1, result_of(1, 0, 0, 1'b1, ONE, ONE));
		add_row(PRESET_FALLOFF, 1'b1, 1'b1, result_of(0, 0, 0, 1'b0, ONE, ONE));
		repeat (4)
			add_row(PRESET_FALLOFF, 1'b0, 1'b0, '0);

		active_preset = PRESET_BOOT;
		foreach (directed[i]) begin
			if (directed[i].preset != active_preset) begin
				settle();
				active_preset = directed[i].preset;
				load_settings(preset_settings(active_preset));
			end
			offer(directed[i].restart_bit, directed[i].known, directed[i].want);
		end

		// mostly plausible vehicles run for long stretches, with some wild settings mixed in
		per_phase = RANDOM_ITEMS / PHASES;
		for (int ph = 0; ph < PHASES; ph++) begin
			mode        = (ph % 3 == 2) ? $urandom_range(1, 2) : 0;
			restart_pct = (mode == 0) ? 2 : 8;
			settle();
			load_settings(draw_settings(mode));
			gap_max   = (ph % 4 == 1) ? 0 : 16;
			stall_max = (ph % 5 == 2) ? 0 : 16;
			for (int n = 0; n < per_phase; n++) begin
				if (n == 0)
					rst = ($urandom_range(0, 4) != 0);
				else
					rst = ($urandom_range(0, 99) < restart_pct);
				offer(rst, 1'b0, '0);
			end
		end

		settle();
		mismatches += results_due.size();
		$display("%0d transactions in (%0d restarts) under %0d register settings,",
			items_sent, restarts_sent, settings_loaded);
		$display("%0d results checked, slip flag changed %0d times, full-scale speed in %0d",
			results_checked, slip_edges, top_speed_hits);
		if (mismatches == 0)
			$display("drivetrain_heun_step_core_tb OK");
		else
			$display("drivetrain_heun_step_core_tb NOT OK");
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("drivetrain_heun_step_core_tb NOT OK");
		$finish;
	end

endmodule
